### rtl/grc_pkg.sv
// ----------------------------------------------------------------------------
// grc_pkg
// Shared constants, sine table and fixed-point helpers of the raycast column engine.
// ----------------------------------------------------------------------------
package grc_pkg;

    localparam int MAP_SIDE  = 16;
    localparam int CELL_SIZE = 64;
    localparam int SPAN_SH   = 14;                  // log2(CELL_SIZE*256)
    localparam logic [23:0] DIST_NO_HIT = 24'hFFFFFF;
    localparam logic [23:0] DIST_MAX    = 24'hFFFFFE;

    localparam logic [16:0] QSIN [0:90] = '{
        17'd0, 17'd1144, 17'd2287, 17'd3430, 17'd4572, 17'd5712, 17'd6850, 17'd7987,
        17'd9121, 17'd10252, 17'd11380, 17'd12505, 17'd13626, 17'd14742, 17'd15855,
        17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336, 17'd22415, 17'd23486,
        17'd24550, 17'd25607, 17'd26656, 17'd27697, 17'd28729, 17'd29753, 17'd30767,
        17'd31772, 17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647, 17'd37590,
        17'd38521, 17'd39441, 17'd40348, 17'd41243, 17'd42126, 17'd42995, 17'd43852,
        17'd44695, 17'd45525, 17'd46341, 17'd47143, 17'd47930, 17'd48703, 17'd49461,
        17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020, 17'd53684, 17'd54332,
        17'd54963, 17'd55578, 17'd56175, 17'd56756, 17'd57319, 17'd57865, 17'd58393,
        17'd58903, 17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183, 17'd61584,
        17'd61966, 17'd62328, 17'd62672, 17'd62997, 17'd63303, 17'd63589, 17'd63856,
        17'd64104, 17'd64332, 17'd64540, 17'd64729, 17'd64898, 17'd65048, 17'd65177,
        17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526, 17'd65536
    };

    // sine in Q.16 of an angle 0..359
    function automatic logic signed [17:0] sin_q16(input logic [8:0] a);
        logic [16:0] m;
        logic        neg;
        begin
            neg = 1'b0;
            if (a <= 9'd90) begin
                m = QSIN[a[6:0]];
            end else if (a <= 9'd180) begin
                m = QSIN[7'(9'd180 - a)];
            end else if (a <= 9'd270) begin
                m = QSIN[7'(a - 9'd180)];
                neg = 1'b1;
            end else begin
                m = QSIN[7'(9'd360 - a)];
                neg = 1'b1;
            end
            sin_q16 = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
        end
    endfunction

    // product shifted right by 16, truncated toward zero
    function automatic logic signed [41:0] mul_shr16(input logic signed [57:0] p);
        logic signed [57:0] adj;
        begin
            adj = (p < 0) ? p + 58'sd65535 : p;
            mul_shr16 = adj[57:16];
        end
    endfunction

    // Q.8 to integer, toward zero, saturated to 16 bits
    function automatic logic [15:0] sat16(input logic signed [31:0] v);
        logic [32:0] av;
        logic [24:0] q;
        begin
            av = (v < 0) ? 33'(-{v[31], v}) : 33'({v[31], v});
            q  = av[32:8];
            if (v < 0) begin
                sat16 = (q > 25'd32768) ? 16'h8000 : 16'(-q);
            end else begin
                sat16 = (q > 25'd32767) ? 16'h7FFF : q[15:0];
            end
        end
    endfunction

endpackage

### rtl/grid_raycast_column_engine_core.sv
// ----------------------------------------------------------------------------
// grid_raycast_column_engine_core
// Wall map store and sequenced ray caster with one shared multiplier and
// one bit-serial divider.
// ----------------------------------------------------------------------------
// A load request writes one map cell. A cast request produces
// RAY_COUNT column results, one per ray, and the input side stays busy until
// the last one is handed to the output register. Each ray takes up to three
// divides in the bit-serial divider (tangent, cotangent, wall height), up to
// nine passes through the shared multiplier, and up to MAX_STEPS+1 map probes
// on each of the two grid-line walks. A stalled output holds the sequence in
// its emit state. The map needs no clearing pass after reset.
module grid_raycast_column_engine_core
    import grc_pkg::*;
#(
    parameter int RAY_COUNT     = 60,
    parameter int MAX_STEPS     = 8,
    parameter int SCREEN_HEIGHT = 320
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [4:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_kind,
    input  logic [3:0]  i_cell_row,
    input  logic [3:0]  i_cell_col,
    input  logic        i_cell_wall,
    input  logic [17:0] i_player_x,
    input  logic [17:0] i_player_y,
    input  logic [8:0]  i_view_angle,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [(RAY_COUNT > 1 ? $clog2(RAY_COUNT) : 1)-1:0] o_column,
    output logic [15:0] o_hit_x,
    output logic [15:0] o_hit_y,
    output logic [23:0] o_distance,
    output logic [$clog2(SCREEN_HEIGHT+1)-1:0]   o_wall_height,
    output logic [$clog2(SCREEN_HEIGHT/2+1)-1:0] o_wall_top,
    output logic        o_vertical_side,
    output logic        o_last
);

    localparam int COL_W = (RAY_COUNT > 1) ? $clog2(RAY_COUNT) : 1;
    localparam int HT_W  = $clog2(SCREEN_HEIGHT + 1);
    localparam int TOP_W = $clog2(SCREEN_HEIGHT / 2 + 1);
    localparam int MS_W  = $clog2(MAP_SIDE);
    localparam int DEPTH = MAP_SIDE * MAP_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int N_W   = $clog2(MAX_STEPS + 1);
    localparam int HALF  = RAY_COUNT / 2;
    localparam logic [32:0] HT_NUM = 33'(CELL_SIZE * SCREEN_HEIGHT * 256);
    localparam logic [HT_W-1:0] HT_MAX = HT_W'(SCREEN_HEIGHT);
    localparam logic [TOP_W-1:0] TOP_MID = TOP_W'(SCREEN_HEIGHT / 2);
    localparam logic signed [31:0] SPAN = 32'sd16384;
    localparam logic [6:0] SIDE7 = 7'(MAP_SIDE);

    typedef enum logic [4:0] {
        S_IDLE, S_ANG, S_VSET, S_HSET, S_DIVR, S_T0, S_T1, S_T2, S_PROBE, S_CHK,
        S_D0, S_D1, S_D2, S_SEL, S_CORR, S_HT, S_EMIT, S_MW
    } t_state;

    t_state r_state, r_ret;

    // map store
    logic           r_map [0:DEPTH-1];
    logic [DEPTH-1:0] r_vld;
    logic           r_rd;
    logic           r_inmap;
    logic [4:0]     r_cols, r_rows;

    // cast context
    logic [17:0]        r_px, r_py;
    logic [8:0]         r_va;
    logic [COL_W-1:0]   r_ray;
    logic signed [17:0] r_s, r_c, r_cc;
    logic               r_hor;
    logic signed [24:0] r_t;
    logic signed [31:0] r_wx, r_wy, r_dx, r_dy;
    logic [N_W-1:0]     r_n;
    logic signed [41:0] r_tmp;
    logic signed [31:0] r_vx, r_vy, r_hx, r_hy;
    logic [23:0]        r_vd, r_hd;
    logic               r_vert;
    logic [HT_W-1:0]    r_ht;

    // shared multiplier
    logic signed [32:0] r_ma;
    logic signed [24:0] r_mb;
    logic signed [57:0] r_prod;

    // bit-serial divider
    logic [32:0] r_dvd, r_quo;
    logic [23:0] r_dvs;
    logic [24:0] r_rem;
    logic [5:0]  r_dcnt;
    logic        r_dneg;

    // output register
    logic               r_ov;
    logic [COL_W-1:0]   r_o_col;
    logic [15:0]        r_o_hx, r_o_hy;
    logic [23:0]        r_o_d;
    logic [HT_W-1:0]    r_o_ht;
    logic [TOP_W-1:0]   r_o_top;
    logic               r_o_vs, r_o_last;

    logic signed [41:0] w_mq;
    logic signed [31:0] w_px, w_py, w_bx, w_by;
    logic signed [32:0] w_ax, w_ay;
    logic [6:0]         w_cols, w_rows;
    logic               w_xin, w_yin;
    logic [AW-1:0]      w_raddr, w_waddr;
    logic [24:0]        w_rsh;
    logic signed [24:0] w_q;
    logic signed [10:0] w_a0;
    logic [8:0]         w_ra, w_rc;
    logic signed [41:0] w_d;
    logic [23:0]        w_fd;
    logic signed [41:0] w_corr;
    logic               w_in_acc, w_out_free;
    logic signed [7:0]  w_cd;
    logic [6:0]         w_cda;

    assign w_mq  = mul_shr16(r_prod);
    assign w_px  = $signed({14'd0, r_px});
    assign w_py  = $signed({14'd0, r_py});
    assign w_bx  = $signed({14'd0, r_px[17:14], 14'd0});
    assign w_by  = $signed({14'd0, r_py[17:14], 14'd0});
    assign w_q   = r_dneg ? -$signed(r_quo[24:0]) : $signed(r_quo[24:0]);

    // map indexing, truncated toward zero
    assign w_ax   = (r_wx < 0) ? -{r_wx[31], r_wx} : {r_wx[31], r_wx};
    assign w_ay   = (r_wy < 0) ? -{r_wy[31], r_wy} : {r_wy[31], r_wy};
    assign w_cols = ({2'd0, r_cols} < SIDE7) ? {2'd0, r_cols} : SIDE7;
    assign w_rows = ({2'd0, r_rows} < SIDE7) ? {2'd0, r_rows} : SIDE7;
    assign w_xin  = (w_ax[32:SPAN_SH] < 19'(w_cols)) && !((r_wx < 0) && (w_ax >= 33'sd16384));
    assign w_yin  = (w_ay[32:SPAN_SH] < 19'(w_rows)) && !((r_wy < 0) && (w_ay >= 33'sd16384));
    assign w_raddr = (w_xin && w_yin) ?
        AW'(w_ay[SPAN_SH +: MS_W] * MAP_SIDE + w_ax[SPAN_SH +: MS_W]) : '0;
    assign w_waddr = AW'(i_cell_row * MAP_SIDE + i_cell_col);

    // ray angle and fisheye correction angle
    assign w_a0 = $signed({2'd0, r_va}) + 11'sd0 + 11'(HALF) - $signed({5'd0, r_ray});
    always_comb begin
        if (w_a0 < 0)             w_ra = 9'(w_a0 + 11'sd360);
        else if (w_a0 >= 11'sd360) w_ra = 9'(w_a0 - 11'sd360);
        else                      w_ra = w_a0[8:0];
        w_rc = (w_ra >= 9'd270) ? w_ra - 9'd270 : w_ra + 9'd90;
    end
    assign w_cd  = $signed({1'b0, r_ray}) - 8'(HALF);
    assign w_cda = (w_cd < 0) ? 7'(-w_cd) : 7'(w_cd);

    assign w_rsh  = {r_rem[23:0], r_dvd[32]};
    assign w_d    = r_tmp - w_mq;
    assign w_fd   = r_vert ? r_vd : r_hd;
    assign w_corr = w_mq;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_ov || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (w_in_acc && !i_kind && (i_cell_row < MAP_SIDE) && (i_cell_col < MAP_SIDE)) begin
            r_map[w_waddr] <= i_cell_wall;
        end
        r_rd    <= r_map[w_raddr] & r_vld[w_raddr];
        r_inmap <= w_xin && w_yin;
        r_prod  <= r_ma * r_mb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_cols <= 5'd8;
            r_rows <= 5'd8;
        end else begin
            if (w_in_acc && !i_kind && (i_cell_row < MAP_SIDE) && (i_cell_col < MAP_SIDE)) begin
                r_vld[w_waddr] <= 1'b1;
            end
            if (i_cfg_we && (i_cfg_idx == 2'd0)) r_cols <= i_cfg_data;
            if (i_cfg_we && (i_cfg_idx == 2'd1)) r_rows <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_ov    <= 1'b0;
            r_ray   <= '0;
            r_n     <= '0;
            r_wx    <= '0;
            r_wy    <= '0;
        end else begin
            if (r_ov && i_out_ready && (r_state != S_EMIT)) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && i_kind) begin
                        r_px    <= i_player_x;
                        r_py    <= i_player_y;
                        r_va    <= (i_view_angle >= 9'd360) ? i_view_angle - 9'd360
                                                            : i_view_angle;
                        r_ray   <= '0;
                        r_state <= S_ANG;
                    end
                end
                S_ANG: begin
                    r_s  <= sin_q16(w_ra);
                    r_c  <= sin_q16(w_rc);
                    r_cc <= $signed({1'b0, QSIN[7'd90 - w_cda]});
                    r_vx <= w_px;
                    r_vy <= w_py;
                    r_hx <= w_px;
                    r_hy <= w_py;
                    r_vd <= DIST_NO_HIT;
                    r_hd <= DIST_NO_HIT;
                    r_state <= S_VSET;
                end
                S_VSET: begin
                    r_hor <= 1'b0;
                    if (r_c != 0) begin
                        r_dvd   <= {(r_s < 0) ? 17'(-r_s) : 17'(r_s), 16'd0};
                        r_dvs   <= 24'((r_c < 0) ? 17'(-r_c) : 17'(r_c));
                        r_dneg  <= r_s[17] ^ r_c[17];
                        r_rem   <= '0;
                        r_dcnt  <= 6'd33;
                        r_ret   <= S_T0;
                        r_state <= S_DIVR;
                    end else begin
                        r_state <= S_HSET;
                    end
                end
                S_HSET: begin
                    r_hor <= 1'b1;
                    if (r_s != 0) begin
                        r_dvd   <= {(r_c < 0) ? 17'(-r_c) : 17'(r_c), 16'd0};
                        r_dvs   <= 24'((r_s < 0) ? 17'(-r_s) : 17'(r_s));
                        r_dneg  <= r_s[17] ^ r_c[17];
                        r_rem   <= '0;
                        r_dcnt  <= 6'd33;
                        r_ret   <= S_T0;
                        r_state <= S_DIVR;
                    end else begin
                        r_state <= S_SEL;
                    end
                end
                S_DIVR: begin
                    r_dvd <= {r_dvd[31:0], 1'b0};
                    if (w_rsh >= {1'b0, r_dvs}) begin
                        r_rem <= w_rsh - {1'b0, r_dvs};
                        r_quo <= {r_quo[31:0], 1'b1};
                    end else begin
                        r_rem <= w_rsh;
                        r_quo <= {r_quo[31:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt - 6'd1;
                    if (r_dcnt == 6'd1) r_state <= r_ret;
                end
                S_T0: begin
                    r_t  <= w_q;
                    r_mb <= w_q;
                    if (!r_hor) begin
                        r_wx <= (r_c > 0) ? w_bx + SPAN : w_bx - 32'sd1;
                        r_ma <= 33'(w_px - ((r_c > 0) ? w_bx + SPAN : w_bx - 32'sd1));
                    end else begin
                        r_wy <= (r_s > 0) ? w_by - 32'sd1 : w_by + SPAN;
                        r_ma <= 33'(w_py - ((r_s > 0) ? w_by - 32'sd1 : w_by + SPAN));
                    end
                    r_ret   <= S_T1;
                    r_state <= S_MW;
                end
                S_T1: begin
                    if (!r_hor) begin
                        r_wy <= w_py + 32'(w_mq);
                        r_ma <= (r_c > 0) ? 33'(SPAN) : -33'(SPAN);
                    end else begin
                        r_wx <= w_px + 32'(w_mq);
                        r_ma <= (r_s > 0) ? -33'(SPAN) : 33'(SPAN);
                    end
                    r_mb    <= r_t;
                    r_ret   <= S_T2;
                    r_state <= S_MW;
                end
                S_T2: begin
                    if (!r_hor) begin
                        r_dx <= (r_c > 0) ? SPAN : -SPAN;
                        r_dy <= -32'(w_mq);
                    end else begin
                        r_dx <= -32'(w_mq);
                        r_dy <= (r_s > 0) ? -SPAN : SPAN;
                    end
                    r_n     <= '0;
                    r_state <= S_PROBE;
                end
                S_PROBE: r_state <= S_CHK;
                S_CHK: begin
                    if ((r_n < N_W'(MAX_STEPS)) && !(r_inmap && r_rd)) begin
                        r_wx    <= r_wx + r_dx;
                        r_wy    <= r_wy + r_dy;
                        r_n     <= r_n + 1'b1;
                        r_state <= S_PROBE;
                    end else begin
                        r_state <= S_D0;
                    end
                end
                S_D0: begin
                    r_ma    <= 33'(r_wx) - 33'(w_px);
                    r_mb    <= 25'(r_c);
                    r_ret   <= S_D1;
                    r_state <= S_MW;
                end
                S_D1: begin
                    r_tmp   <= w_mq;
                    r_ma    <= 33'(r_wy) - 33'(w_py);
                    r_mb    <= 25'(r_s);
                    r_ret   <= S_D2;
                    r_state <= S_MW;
                end
                S_D2: begin
                    if (!r_hor) begin
                        r_vx <= r_wx;
                        r_vy <= r_wy;
                        r_vd <= (w_d < 0) ? 24'd0 :
                                (w_d > 42'sd16777214) ? DIST_MAX : w_d[23:0];
                        r_state <= S_HSET;
                    end else begin
                        r_hx <= r_wx;
                        r_hy <= r_wy;
                        r_hd <= (w_d < 0) ? 24'd0 :
                                (w_d > 42'sd16777214) ? DIST_MAX : w_d[23:0];
                        r_state <= S_SEL;
                    end
                end
                S_SEL: begin
                    r_vert  <= (r_vd < r_hd);
                    r_ma    <= $signed({9'd0, (r_vd < r_hd) ? r_vd : r_hd});
                    r_mb    <= 25'(r_cc);
                    r_ret   <= S_CORR;
                    r_state <= S_MW;
                end
                S_CORR: begin
                    if (w_corr <= 0) begin
                        r_ht    <= HT_MAX;
                        r_state <= S_EMIT;
                    end else begin
                        r_dvd   <= HT_NUM;
                        r_dvs   <= w_corr[23:0];
                        r_dneg  <= 1'b0;
                        r_rem   <= '0;
                        r_dcnt  <= 6'd33;
                        r_ret   <= S_HT;
                        r_state <= S_DIVR;
                    end
                end
                S_HT: begin
                    r_ht    <= (r_quo > 33'(SCREEN_HEIGHT)) ? HT_MAX : HT_W'(r_quo);
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_ov     <= 1'b1;
                        r_o_col  <= r_ray;
                        r_o_hx   <= sat16(r_vert ? r_vx : r_hx);
                        r_o_hy   <= sat16(r_vert ? r_vy : r_hy);
                        r_o_d    <= w_fd;
                        r_o_ht   <= r_ht;
                        r_o_top  <= TOP_MID - TOP_W'(r_ht >> 1);
                        r_o_vs   <= r_vert;
                        r_o_last <= (r_ray == COL_W'(RAY_COUNT - 1));
                        if (r_ray == COL_W'(RAY_COUNT - 1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_ray   <= r_ray + 1'b1;
                            r_state <= S_ANG;
                        end
                    end
                end
                S_MW: r_state <= r_ret;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid     = r_ov;
    assign o_column        = r_o_col;
    assign o_hit_x         = r_o_hx;
    assign o_hit_y         = r_o_hy;
    assign o_distance      = r_o_d;
    assign o_wall_height   = r_o_ht;
    assign o_wall_top      = r_o_top;
    assign o_vertical_side = r_o_vs;
    assign o_last          = r_o_last;

    a_steps_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= N_W'(MAX_STEPS))
        else $error("walk step count beyond limit");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVR) |-> (r_dvs != 24'd0))
        else $error("divider started with zero divisor");

    a_height_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_wall_height <= HT_MAX))
        else $error("wall height above screen height");

    a_busy_cast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_kind) |=> !o_in_ready)
        else $error("cast request did not occupy the engine");

endmodule
